// ----- design/eod_pkg.sv -----
// Shared constants and codes for the envelope onset detector.
// Holds configuration register indexes, field widths and reset values; no dependencies.
package eod_pkg;

    // Configuration port geometry.
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 3;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ATTACK_WEIGHT   = 3'd0,
        CFG_RELEASE_WEIGHT  = 3'd1,
        CFG_THRESHOLD_RATIO = 3'd2,
        CFG_NOISE_FLOOR     = 3'd3,
        CFG_COOLDOWN_FRAMES = 3'd4
    } cfg_index_t;

    // Fixed field widths.
    localparam int WEIGHT_REG_BITS = 24;
    localparam int RATIO_BITS      = 16;
    localparam int RATIO_FRAC      = 12;
    localparam int NOISE_BITS      = 16;
    localparam int COOLDOWN_BITS   = 24;
    localparam int FRAME_BITS      = 32;
    localparam int LEVEL_BITS      = 16;

    // Register values after reset.
    localparam logic [WEIGHT_REG_BITS-1:0] ATTACK_RESET   = 24'd43637;
    localparam logic [WEIGHT_REG_BITS-1:0] RELEASE_RESET  = 24'd1398;
    localparam logic [RATIO_BITS-1:0]      RATIO_RESET    = 16'd12953;
    localparam logic [NOISE_BITS-1:0]      NOISE_RESET    = 16'd491;
    localparam logic [COOLDOWN_BITS-1:0]   COOLDOWN_RESET = 24'd7200;

endpackage

// ----- design/envelope_onset_detector.sv -----
// Envelope onset detector top level: frame peak, envelope update and onset decision.
// Depends on eod_pkg, eod_peak_tracker and eod_serial_mul.
//
//   Channel   Direction  Handshake          Word
//   s_*       in         s_valid/s_ready    sample, frame_end
//   m_*       out        m_valid/m_ready    onset, frame_index, peak, envelope_level
//   cfg_wr_*  in         cfg_wr_en          index, data (no read-back)
//
// A sample without the frame mark is taken whenever the detector is idle. After a frame
// ends, s_ready stays low while the shared serial multiplier walks the weight bits for
// the envelope step and then the 16 ratio bits for the threshold.
// Reset is synchronous and active low; it clears the envelope, counters and peak
// and loads the register defaults. A stalled result holds in the output register
// while further samples of the next frame are still accepted.
module envelope_onset_detector
    import eod_pkg::*;
#(
    parameter int SAMPLE_BITS      = 16,
    parameter int WEIGHT_FRAC_BITS = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SAMPLE_BITS-1:0]    s_sample,
    input  logic                      s_frame_end,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_onset,
    output logic [FRAME_BITS-1:0]     m_frame_index,
    output logic [LEVEL_BITS-1:0]     m_peak,
    output logic [LEVEL_BITS-1:0]     m_envelope_level,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wr_data
);

    localparam int ENV_BITS   = SAMPLE_BITS + WEIGHT_FRAC_BITS;
    localparam int B_BITS     = (WEIGHT_FRAC_BITS > RATIO_BITS) ? WEIGHT_FRAC_BITS : RATIO_BITS;
    localparam int CNT_BITS   = $clog2(B_BITS + 1);
    localparam int WSAT_BITS  = (WEIGHT_FRAC_BITS > WEIGHT_REG_BITS) ?
                                WEIGHT_FRAC_BITS : WEIGHT_REG_BITS;
    localparam int WIDE_BITS  = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    localparam int THR_SHIFT  = WEIGHT_FRAC_BITS + RATIO_FRAC - RATIO_BITS;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_PREP    = 6'b000010,
        ST_UPD_MUL = 6'b000100,
        ST_APPLY   = 6'b001000,
        ST_THR_MUL = 6'b010000,
        ST_DECIDE  = 6'b100000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [WEIGHT_REG_BITS-1:0] attack_weight_reg;
    logic [WEIGHT_REG_BITS-1:0] release_weight_reg;
    logic [RATIO_BITS-1:0]      threshold_ratio_reg;
    logic [NOISE_BITS-1:0]      noise_floor_reg;
    logic [COOLDOWN_BITS-1:0]   cooldown_frames_reg;

    // Detector state.
    logic [ENV_BITS-1:0]    envelope_reg;
    logic [FRAME_BITS-1:0]  frame_count_reg;
    logic [FRAME_BITS-1:0]  last_onset_frame_reg;
    logic                   onset_seen_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic                   rising_reg;

    // Output word.
    logic                   m_valid_reg;
    logic                   m_onset_reg;
    logic [FRAME_BITS-1:0]  m_frame_index_reg;
    logic [LEVEL_BITS-1:0]  m_peak_reg;
    logic [LEVEL_BITS-1:0]  m_level_reg;

    logic                   s_accept;
    logic [SAMPLE_BITS-1:0] peak_now;

    logic                   mul_start;
    logic [ENV_BITS-1:0]    mul_a;
    logic [B_BITS-1:0]      mul_b;
    logic [CNT_BITS-1:0]    mul_nbits;
    logic                   mul_busy;
    logic [ENV_BITS-1:0]    mul_result;

    logic [ENV_BITS-1:0]    peak_fx;
    logic                   rising;
    logic [ENV_BITS-1:0]    env_diff;
    logic [WSAT_BITS-1:0]   weight_wide;
    logic [WSAT_BITS-1:0]   frac_mask_wide;
    logic [WEIGHT_FRAC_BITS-1:0] weight_sat;
    logic [ENV_BITS-1:0]    envelope_next;
    logic [ENV_BITS-1:0]    thr_lhs;
    logic [WIDE_BITS-1:0]   peak_wide;
    logic [WIDE_BITS-1:0]   noise_wide;
    logic [WIDE_BITS-1:0]   level_wide;
    logic [FRAME_BITS-1:0]  frame_dist;
    logic                   onset_hit;
    logic                   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    eod_peak_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_peak (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .sample    (s_sample),
        .frame_end (s_frame_end),
        .peak_now  (peak_now)
    );

    eod_serial_mul #(
        .A_BITS   (ENV_BITS),
        .B_BITS   (B_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .nbits   (mul_nbits),
        .busy    (mul_busy),
        .result  (mul_result)
    );

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_weight_reg   <= ATTACK_RESET;
            release_weight_reg  <= RELEASE_RESET;
            threshold_ratio_reg <= RATIO_RESET;
            noise_floor_reg     <= NOISE_RESET;
            cooldown_frames_reg <= COOLDOWN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ATTACK_WEIGHT:   attack_weight_reg   <= cfg_wr_data[WEIGHT_REG_BITS-1:0];
                CFG_RELEASE_WEIGHT:  release_weight_reg  <= cfg_wr_data[WEIGHT_REG_BITS-1:0];
                CFG_THRESHOLD_RATIO: threshold_ratio_reg <= cfg_wr_data[RATIO_BITS-1:0];
                CFG_NOISE_FLOOR:     noise_floor_reg     <= cfg_wr_data[NOISE_BITS-1:0];
                CFG_COOLDOWN_FRAMES: cooldown_frames_reg <= cfg_wr_data[COOLDOWN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Envelope step setup: direction, distance and the saturated weight.
    assign peak_fx        = {peak_reg, {WEIGHT_FRAC_BITS{1'b0}}};
    assign rising         = peak_fx > envelope_reg;
    assign env_diff       = rising ? (peak_fx - envelope_reg) : (envelope_reg - peak_fx);
    assign weight_wide    = rising ? WSAT_BITS'(attack_weight_reg)
                                   : WSAT_BITS'(release_weight_reg);
    assign frac_mask_wide = WSAT_BITS'({WEIGHT_FRAC_BITS{1'b1}});
    assign weight_sat     = (weight_wide > frac_mask_wide) ? {WEIGHT_FRAC_BITS{1'b1}}
                                                           : weight_wide[WEIGHT_FRAC_BITS-1:0];

    // The step never carries the envelope past the peak.
    assign envelope_next = rising_reg ? (envelope_reg + mul_result)
                                      : (envelope_reg - mul_result);

    // Multiplier loads: weight times distance, then envelope times ratio.
    always_comb begin
        mul_start = 1'b0;
        mul_a     = env_diff;
        mul_b     = B_BITS'(weight_sat);
        mul_nbits = CNT_BITS'(WEIGHT_FRAC_BITS);
        case (state_reg)
            ST_PREP: begin
                mul_start = 1'b1;
            end
            ST_APPLY: begin
                mul_start = 1'b1;
                mul_a     = envelope_next;
                mul_b     = B_BITS'(threshold_ratio_reg);
                mul_nbits = CNT_BITS'(RATIO_BITS);
            end
            default: ;
        endcase
    end

    // Onset decision. Both sides of the ratio test are scaled down by 2^16, which
    // keeps the strict comparison exact against the floored product.
    assign thr_lhs    = ENV_BITS'({peak_reg, {THR_SHIFT{1'b0}}});
    assign peak_wide  = WIDE_BITS'(peak_reg);
    assign noise_wide = WIDE_BITS'(noise_floor_reg);
    assign frame_dist = frame_count_reg - last_onset_frame_reg;
    assign onset_hit  = (thr_lhs > mul_result) && (peak_wide > noise_wide) &&
                        (!onset_seen_reg ||
                         (frame_dist > FRAME_BITS'(cooldown_frames_reg)));
    assign level_wide = WIDE_BITS'(envelope_reg[ENV_BITS-1:WEIGHT_FRAC_BITS]);

    // Sequencer for one frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            envelope_reg         <= '0;
            frame_count_reg      <= '0;
            last_onset_frame_reg <= '0;
            onset_seen_reg       <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && s_frame_end) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    state_reg <= ST_UPD_MUL;
                end
                ST_UPD_MUL: begin
                    if (!mul_busy) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    envelope_reg <= envelope_next;
                    state_reg    <= ST_THR_MUL;
                end
                ST_THR_MUL: begin
                    if (!mul_busy) begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (out_free) begin
                        if (onset_hit) begin
                            onset_seen_reg       <= 1'b1;
                            last_onset_frame_reg <= frame_count_reg;
                        end
                        if (frame_count_reg != {FRAME_BITS{1'b1}}) begin
                            frame_count_reg <= frame_count_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result handshake: valid rises as a word is loaded and falls once it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DECIDE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Frame peak capture and step direction.
    always_ff @(posedge aclk) begin
        if (s_accept && s_frame_end) begin
            peak_reg <= peak_now;
        end
        if (state_reg == ST_PREP) begin
            rising_reg <= rising;
        end
    end

    // Output word, loaded as the result is handed over.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECIDE && out_free) begin
            m_onset_reg       <= onset_hit;
            m_frame_index_reg <= frame_count_reg;
            m_peak_reg        <= peak_wide[LEVEL_BITS-1:0];
            m_level_reg       <= level_wide[LEVEL_BITS-1:0];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_onset          = m_onset_reg;
    assign m_frame_index    = m_frame_index_reg;
    assign m_peak           = m_peak_reg;
    assign m_envelope_level = m_level_reg;

endmodule

// ----- design/eod_serial_mul.sv -----
// Serial-parallel multiplier: one multiplier bit per cycle, LSB first.
// Gives floor(a * b / 2^nbits) exactly; no package dependencies.
module eod_serial_mul #(
    parameter int A_BITS   = 40,
    parameter int B_BITS   = 24,
    parameter int CNT_BITS = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [A_BITS-1:0]   a,
    input  logic [B_BITS-1:0]   b,
    input  logic [CNT_BITS-1:0] nbits,
    output logic                busy,
    output logic [A_BITS-1:0]   result
);

    logic [A_BITS-1:0]   acc_reg;
    logic [A_BITS-1:0]   a_reg;
    logic [B_BITS-1:0]   b_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic [A_BITS:0]     sum;

    // Partial sum for the current multiplier bit; the low bit shifts out each cycle.
    assign sum = {1'b0, acc_reg} + (b_reg[0] ? {1'b0, a_reg} : '0);

    // Control: count down the multiplier bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= (nbits != '0);
            cnt_reg  <= nbits;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: accumulate and shift right, keeping the floor of the product.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end else if (busy_reg) begin
            acc_reg <= sum[A_BITS:1];
            b_reg   <= b_reg >> 1;
        end
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

endmodule

// ----- design/eod_peak_tracker.sv -----
// Running peak magnitude of the channel samples of the current frame.
// Takes the sample word and frame mark; no package dependencies.
module eod_peak_tracker #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   frame_end,
    output logic [SAMPLE_BITS-1:0] peak_now
);

    logic [SAMPLE_BITS-1:0] frame_peak_reg;
    logic [SAMPLE_BITS-1:0] mag;

    // Magnitude of a two's complement sample; the most negative value maps to 2^(S-1).
    assign mag = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

    // Peak including the sample currently offered.
    assign peak_now = (mag > frame_peak_reg) ? mag : frame_peak_reg;

    // Hold the peak until the frame closes, then start over from zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_peak_reg <= '0;
        end else if (accept) begin
            frame_peak_reg <= frame_end ? '0 : peak_now;
        end
    end

endmodule
